// ===== rtl/core/cstrd_pkg.sv =====
// Shared types, constants and helper functions of the stirred-tank derivative block.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package cstrd_pkg;

	localparam int DIV_STAGES   = 12;
	localparam int DIV_BITS     = 4;
	localparam int DIV_W        = DIV_STAGES * DIV_BITS;
	localparam int HORNER_STEPS = 6;
	localparam int LATENCY      = DIV_STAGES + 2 * HORNER_STEPS + 5 + 4;
	localparam int CFG_IDX_W    = 4;
	localparam int CFG_DATA_W   = 44;

	localparam logic signed [31:0] LNK0     = 32'sd419429258;
	localparam logic [30:0]        LOG2E    = 31'd1549082005;
	localparam logic [29:0]        LN2      = 30'd744261118;
	localparam logic [39:0]        Q_MAX    = 40'd1761606538;
	localparam logic [30:0]        ONE30    = 31'h4000_0000;
	localparam logic [60:0]        TERM_CAP = 61'h1000_0000_0000_0000;
	localparam logic [18:0]        T_FLOOR  = 19'd256;

	localparam logic [18:0] INV_VOLUME_RST   = 19'd2560;
	localparam logic [14:0] ACT_TEMP_RST     = 15'd8750;
	localparam logic [17:0] HEAT_GAIN_RST    = 18'd784;
	localparam logic [43:0] WALL_GAIN_RST    = 44'd513752069;
	localparam logic [31:0] POWER_GAIN_RST   = 32'd2630411;
	localparam logic [19:0] FEED_CONC_RST    = 20'd65536;
	localparam logic [18:0] FEED_TEMP_RST    = 19'd89600;
	localparam logic [18:0] COOLANT_TEMP_RST = 19'd76800;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_VOLUME   = 4'd0,
		REG_ACT_TEMP     = 4'd1,
		REG_HEAT_GAIN    = 4'd2,
		REG_WALL_GAIN    = 4'd3,
		REG_POWER_GAIN   = 4'd4,
		REG_FEED_CONC    = 4'd5,
		REG_FEED_TEMP    = 4'd6,
		REG_COOLANT_TEMP = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [20:0] conc;
		logic [18:0]        temp;
		logic [24:0]        flow;
		logic signed [20:0] qpow;
	} item_t;

	typedef struct packed {
		logic [18:0] inv_volume;
		logic [14:0] activation_temp;
		logic [17:0] heat_gain;
		logic [43:0] wall_cooling_gain;
		logic [31:0] power_gain;
		logic [19:0] feed_conc;
		logic [18:0] feed_temp;
		logic [18:0] coolant_temp;
	} cfg_t;

	typedef struct packed {
		item_t              item;
		logic [51:0]        mca;
		logic signed [7:0]  p;
	} exp_res_t;

	function automatic logic [30:0] quarter_pow(input logic [1:0] idx);
		logic [30:0] r;
		case (idx)
			2'd0:    r = 31'd1073741824;
			2'd1:    r = 31'd1276901417;
			2'd2:    r = 31'd1518500250;
			default: r = 31'd1805811301;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] recip_mul(input int n);
		logic [31:0] r;
		case (n)
			3:       r = 32'hAAAA_AAAB;
			5:       r = 32'hCCCC_CCCD;
			6:       r = 32'hAAAA_AAAB;
			default: r = 32'h8000_0000;
		endcase
		return r;
	endfunction

	function automatic int recip_shift(input int n);
		int r;
		case (n)
			1:       r = 31;
			2:       r = 32;
			3:       r = 33;
			4:       r = 33;
			5:       r = 34;
			default: r = 34;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cstrd_div.sv =====
// Pipelined restoring divider: activation temperature * 2^32 over floored temperature.
// Depends on cstrd_pkg; carries the input item alongside the quotient.
`timescale 1ns / 1ps
`default_nettype none

module cstrd_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_vld,
	input  wire cstrd_pkg::item_t in_item,
	input  wire logic [14:0]      act,
	output logic                  out_vld,
	output cstrd_pkg::item_t      out_item,
	output logic [39:0]           quo
);

	localparam int NS = cstrd_pkg::DIV_STAGES;
	localparam int NB = cstrd_pkg::DIV_BITS;
	localparam int DW = cstrd_pkg::DIV_W;

	logic             vld_s  [1:NS];
	cstrd_pkg::item_t item_s [1:NS];
	logic [18:0]      rem_s  [1:NS];
	logic [18:0]      tf_s   [1:NS];
	logic [DW-1:0]    dvd_s  [1:NS];
	logic [DW-1:0]    quo_s  [1:NS];

	genvar k;
	for (k = 0; k < NS; k++) begin : g_stage
		logic             v_in;
		cstrd_pkg::item_t it_in;
		logic [18:0]      rm_in, tf_in, rm_nx;
		logic [DW-1:0]    dv_in, qo_in, dv_nx, qo_nx;
		logic [19:0]      r;

		if (k == 0) begin : g_first
			assign v_in  = in_vld;
			assign it_in = in_item;
			assign tf_in = (in_item.temp < cstrd_pkg::T_FLOOR) ? cstrd_pkg::T_FLOOR : in_item.temp;
			assign rm_in = '0;
			assign dv_in = DW'({act, 32'd0});
			assign qo_in = '0;
		end else begin : g_next
			assign v_in  = vld_s[k];
			assign it_in = item_s[k];
			assign tf_in = tf_s[k];
			assign rm_in = rem_s[k];
			assign dv_in = dvd_s[k];
			assign qo_in = quo_s[k];
		end

		always_comb begin
			rm_nx = rm_in;
			dv_nx = dv_in;
			qo_nx = qo_in;
			r = '0;
			for (int j = 0; j < NB; j++) begin
				r = {rm_nx, dv_nx[DW-1]};
				dv_nx = {dv_nx[DW-2:0], 1'b0};
				if (r >= {1'b0, tf_in}) begin
					r = r - {1'b0, tf_in};
					qo_nx = {qo_nx[DW-2:0], 1'b1};
				end else begin
					qo_nx = {qo_nx[DW-2:0], 1'b0};
				end
				rm_nx = r[18:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			item_s[k+1] <= it_in;
			tf_s[k+1]   <= tf_in;
			rem_s[k+1]  <= rm_nx;
			dvd_s[k+1]  <= dv_nx;
			quo_s[k+1]  <= qo_nx;
		end
	end

	assign out_vld  = vld_s[NS];
	assign out_item = item_s[NS];
	assign quo      = quo_s[NS][39:0];

endmodule

`default_nettype wire

// ===== rtl/core/cstrd_exp.sv =====
// Rate constant pipeline: exponent, base-2 split, Horner series for 2^frac, times concentration.
// Depends on cstrd_pkg; fed by cstrd_div.
`timescale 1ns / 1ps
`default_nettype none

module cstrd_exp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_vld,
	input  wire cstrd_pkg::item_t in_item,
	input  wire logic [39:0]      quo,
	output logic                  out_vld,
	output cstrd_pkg::exp_res_t   res
);

	localparam int HS = cstrd_pkg::HORNER_STEPS;

	typedef struct packed {
		cstrd_pkg::item_t  item;
		logic [27:0]       z;
		logic [1:0]        idx;
		logic signed [7:0] p;
		logic              ok;
	} hcar_t;

	logic                    v_s1, v_s2, v_s3, v_s16, v_s17;
	cstrd_pkg::item_t        item_s1, item_s2, item_s3;
	logic                    ok_s1, ok_s2, ok_s3;
	logic signed [31:0]      x_s1;
	logic signed [63:0]      prod_s2;
	logic [51:0]             zp_s3;
	logic [1:0]              idx_s3;
	logic signed [7:0]       p_s3;
	hcar_t                   c3;
	hcar_t                   c_s16, c_s17;
	logic [31:0]             m_s16;
	logic [51:0]             mca_s17;
	logic [61:0]             mprod;
	logic [19:0]             ca;

	logic                    hv_s [1:2*HS];
	hcar_t                   hc_s [1:2*HS];
	logic [28:0]             hw_s [0:HS-1];
	logic [30:0]             ha_s [1:HS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s16 <= 1'b0;
			v_s17 <= 1'b0;
		end else begin
			v_s1  <= in_vld;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s16 <= hv_s[2*HS];
			v_s17 <= v_s16;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		ok_s1   <= (quo <= cstrd_pkg::Q_MAX);
		x_s1    <= (quo <= cstrd_pkg::Q_MAX) ? (cstrd_pkg::LNK0 - $signed(quo[31:0])) : 32'sd0;
		item_s2 <= item_s1;
		ok_s2   <= ok_s1;
		prod_s2 <= $signed(x_s1) * $signed({1'b0, cstrd_pkg::LOG2E});
		item_s3 <= item_s2;
		ok_s3   <= ok_s2;
		p_s3    <= prod_s2[61:54];
		idx_s3  <= prod_s2[53:52];
		zp_s3   <= 52'(prod_s2[51:30]) * 52'(cstrd_pkg::LN2);
	end

	always_comb begin
		c3.item = item_s3;
		c3.z    = zp_s3[51:24];
		c3.idx  = idx_s3;
		c3.p    = p_s3;
		c3.ok   = ok_s3;
	end

	genvar k;
	for (k = 0; k < HS; k++) begin : g_step
		localparam int          N = HS - k;
		localparam logic [31:0] M = cstrd_pkg::recip_mul(N);
		localparam int          S = cstrd_pkg::recip_shift(N);
		logic        v_in;
		hcar_t       c_in;
		logic [30:0] a_in;
		logic [58:0] aprod;
		logic [60:0] bprod;

		if (k == 0) begin : g_first
			assign v_in = v_s3;
			assign c_in = c3;
			assign a_in = cstrd_pkg::ONE30;
		end else begin : g_next
			assign v_in = hv_s[2*k];
			assign c_in = hc_s[2*k];
			assign a_in = ha_s[k];
		end

		assign aprod = 59'(a_in) * 59'(c_in.z);
		assign bprod = 61'(hw_s[k]) * 61'(M);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hv_s[2*k+1] <= 1'b0;
				hv_s[2*k+2] <= 1'b0;
			end else begin
				hv_s[2*k+1] <= v_in;
				hv_s[2*k+2] <= hv_s[2*k+1];
			end
		end

		always_ff @(posedge clk) begin
			hc_s[2*k+1] <= c_in;
			hw_s[k]     <= aprod[58:30];
			hc_s[2*k+2] <= hc_s[2*k+1];
			ha_s[k+1]   <= cstrd_pkg::ONE30 + 31'(bprod >> S);
		end
	end

	assign mprod = 62'(cstrd_pkg::quarter_pow(hc_s[2*HS].idx)) * 62'(ha_s[HS]);
	assign ca    = c_s16.item.conc[20] ? 20'd0 : c_s16.item.conc[19:0];

	always_ff @(posedge clk) begin
		c_s16   <= hc_s[2*HS];
		m_s16   <= mprod[61:30];
		c_s17   <= c_s16;
		mca_s17 <= c_s16.ok ? (52'(m_s16) * 52'(ca)) : 52'd0;
	end

	assign out_vld  = v_s17;
	assign res.item = c_s17.item;
	assign res.mca  = mca_s17;
	assign res.p    = c_s17.p;

endmodule

`default_nettype wire

// ===== rtl/core/cstr_reactor_derivative.sv =====
// Top level of the stirred-tank derivative block: config registers, balance terms, output.
// Depends on cstrd_pkg, cstrd_div and cstrd_exp.
//
// Usage:
//   Input channel: an item (concentration, temperature, flow_rate, cooling_power) is taken at
//   each rising edge with start high and busy low. A new item may be given every cycle.
//   Result channel: done is high for one cycle with conc_rate and temp_rate; the receiver
//   takes it at the edge that ends that cycle and cannot hold it off.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0..7 selects
//   inv_volume, activation_temp, heat_gain, wall_cooling_gain, power_gain, feed_conc,
//   feed_temp, coolant_temp. Other indexes are dropped. Write only while no item is in flight.
//   Results: one result per accepted item, in order.
//   Throughput: one item per cycle. The depth is set by the 12-stage divider (4 quotient
//   bits per stage), the 12-stage Horner series (multiply, then reciprocal multiply per
//   term), and the multiplier stages of the rate and balance terms.
//   Reset: pipeline valid bits clear, registers take their defaults, busy stays high until
//   the first cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none

module cstr_reactor_derivative (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [20:0]                concentration,
	input  wire logic [18:0]                       temperature,
	input  wire logic [24:0]                       flow_rate,
	input  wire logic signed [20:0]                cooling_power,
	output logic                                   done,
	output logic signed [31:0]                     conc_rate,
	output logic signed [31:0]                     temp_rate,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [cstrd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cstrd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic                 ready_q;
	cstrd_pkg::cfg_t      cfg_q;
	cstrd_pkg::item_t     in_item;
	logic                 div_vld, exp_vld;
	cstrd_pkg::item_t     div_item;
	logic [39:0]          div_quo;
	cstrd_pkg::exp_res_t  er;

	function automatic logic signed [63:0] sterm(input logic [60:0] mag, input logic neg);
		logic signed [63:0] v;
		v = $signed({3'b000, mag});
		return neg ? -v : v;
	endfunction

	assign busy      = !ready_q;
	assign cfg_ready = ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_volume        <= cstrd_pkg::INV_VOLUME_RST;
			cfg_q.activation_temp   <= cstrd_pkg::ACT_TEMP_RST;
			cfg_q.heat_gain         <= cstrd_pkg::HEAT_GAIN_RST;
			cfg_q.wall_cooling_gain <= cstrd_pkg::WALL_GAIN_RST;
			cfg_q.power_gain        <= cstrd_pkg::POWER_GAIN_RST;
			cfg_q.feed_conc         <= cstrd_pkg::FEED_CONC_RST;
			cfg_q.feed_temp         <= cstrd_pkg::FEED_TEMP_RST;
			cfg_q.coolant_temp      <= cstrd_pkg::COOLANT_TEMP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cstrd_pkg::REG_INV_VOLUME:   cfg_q.inv_volume        <= cfg_data[18:0];
				cstrd_pkg::REG_ACT_TEMP:     cfg_q.activation_temp   <= cfg_data[14:0];
				cstrd_pkg::REG_HEAT_GAIN:    cfg_q.heat_gain         <= cfg_data[17:0];
				cstrd_pkg::REG_WALL_GAIN:    cfg_q.wall_cooling_gain <= cfg_data[43:0];
				cstrd_pkg::REG_POWER_GAIN:   cfg_q.power_gain        <= cfg_data[31:0];
				cstrd_pkg::REG_FEED_CONC:    cfg_q.feed_conc         <= cfg_data[19:0];
				cstrd_pkg::REG_FEED_TEMP:    cfg_q.feed_temp         <= cfg_data[18:0];
				cstrd_pkg::REG_COOLANT_TEMP: cfg_q.coolant_temp      <= cfg_data[18:0];
				default: ;
			endcase
		end
	end

	assign in_item.conc = concentration;
	assign in_item.temp = temperature;
	assign in_item.flow = flow_rate;
	assign in_item.qpow = cooling_power;

	cstrd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start && !busy),
		.in_item  (in_item),
		.act      (cfg_q.activation_temp),
		.out_vld  (div_vld),
		.out_item (div_item),
		.quo      (div_quo)
	);

	cstrd_exp u_exp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (div_vld),
		.in_item (div_item),
		.quo     (div_quo),
		.out_vld (exp_vld),
		.res     (er)
	);

	// stage 1: flow ratio, differences, wall and power terms, rate term products
	logic [19:0]        ca;
	logic signed [21:0] dc;
	logic signed [19:0] dt, dw;
	logic [20:0]        dc_abs, qp_abs;
	logic [18:0]        dt_abs, dw_abs;
	logic [62:0]        p5;
	logic [52:0]        p6;
	logic signed [8:0]  e2, e4;
	logic [73:0]        shl2;
	logic [60:0]        t2;

	assign ca     = er.item.conc[20] ? 20'd0 : er.item.conc[19:0];
	assign dc     = $signed({2'b00, cfg_q.feed_conc}) - $signed({2'b00, ca});
	assign dt     = $signed({1'b0, cfg_q.feed_temp}) - $signed({1'b0, er.item.temp});
	assign dw     = $signed({1'b0, er.item.temp}) - $signed({1'b0, cfg_q.coolant_temp});
	assign dc_abs = dc[21] ? 21'(-dc) : 21'(dc);
	assign dt_abs = dt[19] ? 19'(-dt) : 19'(dt);
	assign dw_abs = dw[19] ? 19'(-dw) : 19'(dw);
	assign qp_abs = er.item.qpow[20] ? 21'(-er.item.qpow) : 21'(er.item.qpow);
	assign p5     = 63'(cfg_q.wall_cooling_gain) * 63'(dw_abs);
	assign p6     = 53'(cfg_q.power_gain) * 53'(qp_abs);
	assign e2     = 9'(er.p) - 9'sd14;
	assign e4     = 9'sd38 - 9'(er.p);
	assign shl2   = 74'(er.mca) << e2[4:0];

	always_comb begin
		if (!e2[8]) begin
			t2 = (shl2 > 74'(cstrd_pkg::TERM_CAP)) ? cstrd_pkg::TERM_CAP : shl2[60:0];
		end else begin
			t2 = 61'(er.mca >> 8'(-e2));
		end
	end

	logic               v_s1;
	logic [43:0]        f_s1;
	logic [20:0]        dc_abs_s1;
	logic [18:0]        dt_abs_s1;
	logic               dc_neg_s1, dt_neg_s1, dw_neg_s1, qp_neg_s1;
	logic [46:0]        t5_s1;
	logic [36:0]        t6_s1;
	logic [69:0]        p4_s1;
	logic [60:0]        t2_s1;
	logic [7:0]         sh4_s1;

	// stage 2: flow terms and heat term shift
	logic [64:0]        p1;
	logic [62:0]        p3;
	logic [69:0]        shr4;

	assign p1   = 65'(f_s1) * 65'(dc_abs_s1);
	assign p3   = 63'(f_s1) * 63'(dt_abs_s1);
	assign shr4 = p4_s1 >> sh4_s1;

	logic               v_s2;
	logic               dc_neg_s2, dt_neg_s2, dw_neg_s2, qp_neg_s2;
	logic [48:0]        t1_s2;
	logic [46:0]        t3_s2;
	logic [60:0]        t4_s2;
	logic [60:0]        t2_s2;
	logic [46:0]        t5_s2;
	logic [36:0]        t6_s2;

	// stage 3: signed sums
	logic               v_s3;
	logic signed [63:0] accc_s3, acct_s3;

	// stage 4: floor, saturate, present
	logic signed [63:0] oc, ot;
	logic               v_s4;
	logic signed [31:0] conc_rate_s4, temp_rate_s4;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign oc = accc_s3 >>> 16;
	assign ot = acct_s3 >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= exp_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		f_s1      <= 44'(er.item.flow) * 44'(cfg_q.inv_volume);
		dc_abs_s1 <= dc_abs;
		dt_abs_s1 <= dt_abs;
		dc_neg_s1 <= dc[21];
		dt_neg_s1 <= dt[19];
		dw_neg_s1 <= dw[19];
		qp_neg_s1 <= er.item.qpow[20];
		t5_s1     <= p5[62:16];
		t6_s1     <= p6[52:16];
		p4_s1     <= 70'(er.mca) * 70'(cfg_q.heat_gain);
		t2_s1     <= t2;
		sh4_s1    <= e4[7:0];

		dc_neg_s2 <= dc_neg_s1;
		dt_neg_s2 <= dt_neg_s1;
		dw_neg_s2 <= dw_neg_s1;
		qp_neg_s2 <= qp_neg_s1;
		t1_s2     <= p1[64:16];
		t3_s2     <= p3[62:16];
		t4_s2     <= (shr4 > 70'(cstrd_pkg::TERM_CAP)) ? cstrd_pkg::TERM_CAP : shr4[60:0];
		t2_s2     <= t2_s1;
		t5_s2     <= t5_s1;
		t6_s2     <= t6_s1;

		accc_s3 <= sterm(61'(t1_s2), dc_neg_s2) - sterm(t2_s2, 1'b0);
		acct_s3 <= sterm(61'(t3_s2), dt_neg_s2) + sterm(t4_s2, 1'b0)
			+ sterm(61'(t5_s2), !dw_neg_s2) + sterm(61'(t6_s2), !qp_neg_s2);

		conc_rate_s4 <= sat32(oc);
		temp_rate_s4 <= sat32(ot);
	end

	assign done      = v_s4;
	assign conc_rate = conc_rate_s4;
	assign temp_rate = temp_rate_s4;

endmodule

`default_nettype wire

// ===== rtl/core/cstrd_checker.sv =====
// Port-level checks of the stirred-tank derivative block, bound to its top level.
// Depends on cstrd_pkg and cstr_reactor_derivative.
`timescale 1ns / 1ps
`default_nettype none

module cstrd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic cfg_ready
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(cstrd_pkg::LATENCY) done)
		else $error("accepted transaction gave no result at the pipeline latency");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, cstrd_pkg::LATENCY))
		else $error("result without an accepted transaction");

	a_cfg_ready_tracks: assert property (@(posedge clk)
		cfg_ready == !busy)
		else $error("config ready and input busy disagree");

	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose outside reset");

endmodule

bind cstr_reactor_derivative cstrd_checker u_cstrd_checker (.*);

`default_nettype wire
